// ----- rtl/core/sdd_pkg.sv -----
// Shared constants, types and helper functions for the signed binary to decimal converter.
package sdd_pkg;

    localparam int MAX_WORDS     = 4;
    localparam int WORD_BITS     = 32;
    localparam int DEFAULT_WORDS = 4;
    localparam int FIELD_BITS    = 64;
    localparam int DIGIT_BITS    = 4;

    // Control from the sequencer to the shift-and-adjust unit
    typedef struct packed {
        logic load;      // take a new magnitude, clear the BCD register
        logic step;      // one double-dabble iteration
        logic shift;     // drop the top digit, move the rest up
    } dabble_ctrl_t;

    function automatic int clamp_words(int words);
        int w;
        w = words;
        if (w < 1)
            w = 1;
        if (w > MAX_WORDS)
            w = MAX_WORDS;
        return w;
    endfunction

    // Decimal digits needed for 2**(32*words)-1
    function automatic int digits_for(int words);
        int n;
        case (clamp_words(words))
            1:       n = 10;
            2:       n = 20;
            3:       n = 29;
            default: n = 39;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/core/sdd_stream_if.sv -----
// Valid/ready stream interfaces for the converter's input and result channels.
interface sdd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_high;
    logic [63:0] value_low;

    modport source (output valid, output value_high, output value_low, input ready);
    modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface sdd_out_if;
    logic       valid;
    logic       ready;
    logic       is_minus;
    logic [3:0] digit;
    logic       last;

    modport source (output valid, output is_minus, output digit, output last, input ready);
    modport sink   (input valid, input is_minus, input digit, input last, output ready);
endinterface

// ----- rtl/core/sdd_dabble_unit.sv -----
// Shift-and-add-3 unit: holds the binary magnitude and BCD digits, one iteration per cycle while step is set.
module sdd_dabble_unit
    import sdd_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WORDS * WORD_BITS,
    parameter int NDIG  = digits_for(DEFAULT_WORDS)
)
(
    input  logic                  clk,
    input  dabble_ctrl_t          ctrl,
    input  logic [WIDTH-1:0]      value,
    input  logic                  negate,
    output logic [DIGIT_BITS-1:0] top_digit
);

    localparam int BCD_BITS = DIGIT_BITS * NDIG;

    logic [WIDTH-1:0]    bin_reg;
    logic [WIDTH-1:0]    bin_next;
    logic [BCD_BITS-1:0] bcd_reg;
    logic [BCD_BITS-1:0] bcd_next;
    logic [BCD_BITS-1:0] bcd_adj;

    // add 3 to every digit of 5 or more, all digits in parallel
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[DIGIT_BITS*i +: DIGIT_BITS] >= DIGIT_BITS'(5))
                bcd_adj[DIGIT_BITS*i +: DIGIT_BITS] =
                    bcd_reg[DIGIT_BITS*i +: DIGIT_BITS] + DIGIT_BITS'(3);
            else
                bcd_adj[DIGIT_BITS*i +: DIGIT_BITS] = bcd_reg[DIGIT_BITS*i +: DIGIT_BITS];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            // full-width two's complement negation
            bin_next = negate ? (~value + WIDTH'(1)) : value;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            {bcd_next, bin_next} = {bcd_adj, bin_reg} << 1;
        end
        else if (ctrl.shift)
        begin
            bcd_next = {bcd_reg[BCD_BITS-DIGIT_BITS-1:0], DIGIT_BITS'(0)};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_BITS-1 -: DIGIT_BITS];

endmodule

// ----- rtl/core/signed_binary_to_decimal_digits.sv -----
// Top level: signed 128-bit binary to decimal text converter with sequencer and result register.
//
// Usage
//   din  : one transfer carries a two's complement value as value_high:value_low.
//          Only the low WORDS*32 bits are used; bit WORDS*32-1 is the sign.
//   dout : one transfer per symbol. A negative value first gives a minus-sign
//          symbol (is_minus=1, digit=0, last=0), then the magnitude's digits,
//          most significant first, no leading zeros; last marks the final digit.
//          Zero gives the single digit 0.
// Timing
//   WORDS*32 shift-and-add-3 iterations of double dabble run one per cycle in the
//   shared unit, then leading zeros are dropped one per cycle, then symbols leave
//   one per cycle while dout.ready allows. Zeros dropped plus digits always make
//   NDIG. din.ready is high only while idle; the next value is accepted while the
//   final digit still waits in the result register.
// Stall
//   dout holds its symbol while dout.ready is low; the sequencer waits.
// Reset
//   rst_n (asynchronous, active low) returns to idle with no result pending.
//
module signed_binary_to_decimal_digits
    import sdd_pkg::*;
#(
    parameter int WORDS = DEFAULT_WORDS
)
(
    input  logic     clk,
    input  logic     rst_n,
    sdd_in_if.sink   din,
    sdd_out_if.source dout
);

    localparam int WN     = clamp_words(WORDS);
    localparam int WIDTH  = WN * WORD_BITS;
    localparam int NDIG   = digits_for(WN);
    localparam int ITER_W = $clog2(WIDTH + 1);
    localparam int DCNT_W = $clog2(NDIG + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic                  minus_reg, minus_next;

    // result register
    logic                  ovalid_reg, ovalid_next;
    logic                  ominus_reg, ominus_next;
    logic [DIGIT_BITS-1:0] odigit_reg, odigit_next;
    logic                  olast_reg, olast_next;

    logic [2*FIELD_BITS-1:0] raw;
    logic [WIDTH-1:0]        value;
    logic                    negate;
    logic [DIGIT_BITS-1:0]   top_digit;
    logic                    slot_free;
    dabble_ctrl_t            ctrl;

    assign raw    = {din.value_high, din.value_low};
    assign value  = raw[WIDTH-1:0];
    assign negate = raw[WIDTH-1];

    // result slot can take a symbol when empty or being drained this cycle
    assign slot_free = !ovalid_reg || dout.ready;

    assign din.ready = (state_reg == ST_IDLE);

    sdd_dabble_unit #(
        .WIDTH (WIDTH),
        .NDIG  (NDIG)
    ) u_dabble (
        .clk       (clk),
        .ctrl      (ctrl),
        .value     (value),
        .negate    (negate),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        dcnt_next   = dcnt_reg;
        minus_next  = minus_reg;
        ctrl        = '0;
        ovalid_next = ovalid_reg && !dout.ready;
        ominus_next = ominus_reg;
        odigit_next = odigit_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    ctrl.load  = 1'b1;
                    minus_next = negate;
                    iter_next  = ITER_W'(WIDTH);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.step = 1'b1;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    dcnt_next  = DCNT_W'(NDIG);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep at least one digit
                if (top_digit == '0 && dcnt_reg > DCNT_W'(1))
                begin
                    ctrl.shift = 1'b1;
                    dcnt_next  = dcnt_reg - DCNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    if (minus_reg)
                    begin
                        minus_next  = 1'b0;
                        ominus_next = 1'b1;
                        odigit_next = '0;
                        olast_next  = 1'b0;
                    end
                    else
                    begin
                        ctrl.shift  = 1'b1;
                        ominus_next = 1'b0;
                        odigit_next = top_digit;
                        olast_next  = (dcnt_reg == DCNT_W'(1));
                        dcnt_next   = dcnt_reg - DCNT_W'(1);
                        if (dcnt_reg == DCNT_W'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            minus_reg  <= 1'b0;
            iter_reg   <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            minus_reg  <= minus_next;
            iter_reg   <= iter_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ominus_reg <= ominus_next;
        odigit_reg <= odigit_next;
        olast_reg  <= olast_next;
    end

    assign dout.valid    = ovalid_reg;
    assign dout.is_minus = ominus_reg;
    assign dout.digit    = odigit_reg;
    assign dout.last     = olast_reg;

`ifndef NO_ASSERTIONS
    a_minus_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ominus_reg) |-> (odigit_reg == '0 && !olast_reg))
        else $error("minus symbol carries a digit or last flag");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (odigit_reg <= DIGIT_BITS'(9)))
        else $error("emitted digit above nine");

    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> (state_reg == ST_CONV))
        else $error("accepted value did not start conversion");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> (dcnt_reg != '0))
        else $error("digit count empty while emitting");
`endif

endmodule

// ----- dv/signed_binary_to_decimal_digits_tb.sv -----
// Self-checking testbench for the signed binary to decimal digits converter.
module signed_binary_to_decimal_digits_tb
    import sdd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Width under test; the predictor clamps it the same way the block does.
    localparam int TB_WORDS   = DEFAULT_WORDS;
    localparam int USED_WORDS = (TB_WORDS < 1) ? 1 :
                                (TB_WORDS > MAX_WORDS) ? MAX_WORDS : TB_WORDS;
    localparam int VALUE_BITS = USED_WORDS * WORD_BITS;

    localparam int RANDOM_ITEMS  = 100;
    localparam int DRAIN_EVERY   = 40;   // random transfers between full drains
    localparam int IDLE_LIMIT    = 3000; // cycles with no transfer on either side
    localparam int SETTLE_CYCLES = 250;  // longer than one full conversion, to catch strays

    // One symbol of decimal text as it leaves the block.
    typedef struct packed {
        logic       is_minus;
        logic [3:0] digit;
        logic       last;
    } symbol_t;

    logic clk;
    logic rst_n;

    sdd_in_if  din ();
    sdd_out_if dout ();

    signed_binary_to_decimal_digits #(
        .WORDS (TB_WORDS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    // Symbols still owed by the block, oldest first.
    symbol_t expected_symbols [$];
    int      error_count = 0;
    int      burst_left  = 0;

    logic [15:0] accept_pattern = '1;
    int          pattern_slot   = 0;

    // Directed table. Text is filled in where it is obvious; an empty string
    // means the row is checked against the predictor instead.
    localparam int DIRECTED_ROWS = 23;

    logic [63:0] row_high [DIRECTED_ROWS] = '{
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
        64'h1,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'h4B3B_4CA8_5A86_C47A,
        64'h0000_0000_0000_0036,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0
    };

    logic [63:0] row_low [DIRECTED_ROWS] = '{
        64'h0,
        64'd1,
        64'd9,
        64'd10,
        64'd123,
        64'd999999999,
        64'h0000_0000_FFFF_FFFF,
        64'h0000_0001_0000_0000,
        64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFF6,
        64'h0,
        64'h0000_0000_0000_0001,
        64'h098A_2240_0000_0000,
        64'h35C9_ADC5_DEA0_0000,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555,
        64'hFFFF_FFFF_FFFF_FF85,
        64'd100
    };

    string row_text [DIRECTED_ROWS] = '{
        "0",                                           // zero: single digit
        "1",
        "9",
        "10",                                          // first carry into tens
        "123",
        "999999999",
        "4294967295",                                  // top of one word
        "4294967296",                                  // carry into second word
        "9223372036854775808",
        "18446744073709551615",                        // top of the low half
        "18446744073709551616",                        // carry into the high half
        "170141183460469231731687303715884105727",     // most positive
        "-170141183460469231731687303715884105728",    // most negative, 39 digits
        "-1",
        "-10",
        "-18446744073709551616",
        "",                                            // most negative plus one
        "",                                            // ten to the 38th
        "",                                            // ten to the 21st
        "",
        "",
        "-123",
        "100"
    };

    // Clock and the one reset at the start of the run.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Decimal text of a two's complement value at the block's width:
    // optional minus sign, then the magnitude with no leading zeros.
    function automatic void predict_decimal_text(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] width_mask;
        logic [127:0] magnitude;
        logic [3:0]   digits [$];
        symbol_t      sym;
        width_mask = (VALUE_BITS >= 128) ? '1 : ((128'd1 << VALUE_BITS) - 128'd1);
        magnitude  = {hi, lo} & width_mask;
        if (magnitude[VALUE_BITS-1])
        begin
            // true increment across the whole width, so the most negative
            // value comes out as its full unsigned magnitude
            magnitude = (~magnitude + 128'd1) & width_mask;
            sym = '{is_minus: 1'b1, digit: 4'd0, last: 1'b0};
            expected_symbols.push_back(sym);
        end
        do
        begin
            digits.push_front(4'(magnitude % 128'd10));
            magnitude = magnitude / 128'd10;
        end
        while (magnitude != 128'd0);
        foreach (digits[i])
        begin
            sym = '{is_minus: 1'b0, digit: digits[i], last: (i == digits.size() - 1)};
            expected_symbols.push_back(sym);
        end
    endfunction

    // Same, but from text written out by hand in the table.
    function automatic void expect_written_text(input string text);
        symbol_t sym;
        for (int i = 0; i < text.len(); i++)
        begin
            if (text[i] == "-")
                sym = '{is_minus: 1'b1, digit: 4'd0, last: 1'b0};
            else
                sym = '{is_minus: 1'b0, digit: 4'(text[i] - "0"),
                        last: (i == text.len() - 1)};
            expected_symbols.push_back(sym);
        end
    endfunction

    // Random values, weighted so that digit counts, signs and the decimal and
    // binary boundaries are all well visited rather than just 38-39 digits.
    function automatic logic [127:0] pick_value();
        logic [127:0] v;
        int           pick;
        v    = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2:
                ;                                  // full-width noise
            3, 4, 5:
            begin
                v = v >> $urandom_range(0, 127);   // random length
                if ($urandom_range(0, 1))
                    v = -v;
            end
            6:
            begin
                v = 128'd1;                        // power of ten and neighbours
                repeat ($urandom_range(0, 38)) v = v * 128'd10;
                v = v + 128'($urandom_range(0, 2)) - 128'd1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            7:
            begin
                v = 128'($urandom_range(0, 20));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            8:
            begin
                if ($urandom_range(0, 1))
                    v = {1'b0, {127{1'b1}}} - 128'($urandom_range(0, 3));
                else
                    v = {1'b1, 127'd0} + 128'($urandom_range(0, 3));
            end
            default:
                v = (128'd1 << $urandom_range(0, 127)) - 128'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    // One input transfer. The sender works in bursts separated by random gaps;
    // with drain set it first holds off until every owed symbol has arrived.
    task automatic send_value(input logic [63:0] hi, input logic [63:0] lo,
                              input string text, input bit drain);
        int gap;
        if (drain)
        begin
            din.valid <= 1'b0;
            do @(posedge clk); while (expected_symbols.size() != 0);
            burst_left = 0;
        end
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                din.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        din.valid      <= 1'b1;
        din.value_high <= hi;
        din.value_low  <= lo;
        @(posedge clk);
        while (din.ready !== 1'b1) @(posedge clk);
        if (text.len() == 0)
            predict_decimal_text(hi, lo);
        else
            expect_written_text(text);
    endtask

    // Stimulus: directed table, then the random run, then drain and verdict.
    initial
    begin
        logic [127:0] v;
        din.valid      <= 1'b0;
        din.value_high <= '0;
        din.value_low  <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_value(row_high[r], row_low[r], row_text[r], 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            v = pick_value();
            send_value(v[127:64], v[63:0], "", (n % DRAIN_EVERY) == 0);
        end

        din.valid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** signed_binary_to_decimal_digits: PASSED **");
        else
            $display("** signed_binary_to_decimal_digits: FAILED **");
        $finish;
    end

    // Receiver: ready follows a random 16-bit pattern, re-chosen each time the slot counter wraps.
    // Bit 0 is forced high so the longest stall stays bounded.
    initial
    begin
        dout.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pattern_slot == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       accept_pattern = '1;               // no stalls at all
                    1:       accept_pattern = 16'($urandom);
                    2:       accept_pattern = 16'($urandom & $urandom);
                    default: accept_pattern = 16'($urandom | $urandom);
                endcase
                accept_pattern[0] = 1'b1;
            end
            dout.ready   <= accept_pattern[pattern_slot % 16];
            pattern_slot = (pattern_slot + 1) % 48;
        end
    end

    // Result checker: every symbol transfer against the oldest owed symbol.
    always @(posedge clk)
    begin
        symbol_t want;
        if (rst_n === 1'b1 && dout.valid === 1'b1 && dout.ready === 1'b1)
        begin
            if (expected_symbols.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected symbol minus=%0b digit=%0d last=%0b",
                         $time, dout.is_minus, dout.digit, dout.last);
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (dout.is_minus !== want.is_minus || dout.digit !== want.digit
                    || dout.last !== want.last)
                begin
                    error_count++;
                    $display("%0t: expected minus=%0b digit=%0d last=%0b, got minus=%0b digit=%0d last=%0b",
                             $time, want.is_minus, want.digit, want.last,
                             dout.is_minus, dout.digit, dout.last);
                end
            end
        end
    end

    // Watchdog: a long stretch with no transfer on either side means a hang.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((din.valid === 1'b1 && din.ready === 1'b1)
                || (dout.valid === 1'b1 && dout.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d symbols still owed",
                 $time, IDLE_LIMIT, expected_symbols.size());
        $display("** signed_binary_to_decimal_digits: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sdd_pkg.sv
rtl/core/sdd_stream_if.sv
rtl/core/sdd_dabble_unit.sv
rtl/core/signed_binary_to_decimal_digits.sv
dv/signed_binary_to_decimal_digits_tb.sv
